// ===== hdl/scb_pkg.sv =====
// Shared types and constants for the statistics counter bank.
// Holds the request and response beat layouts, codes and the controller state type.
// No dependencies; every other file of the block refers to it by scoped names.
package scb_pkg;

   localparam int IDX_W     = 8;
   localparam int VALUE_W   = 64;
   localparam int RATIO_W   = 7;
   localparam int NUM_W     = 72;   // weighted blend sum, |sum| <= 100 * 2^63
   localparam int MAG_W     = 71;   // magnitude of that sum

   // Divide by 100: DIV_DIGIT_W dividend bits per step, DIV_STEPS steps cover DIV_DVD_W >= MAG_W
   localparam int DIV_DIGIT_W = 18;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_DVD_W   = 72;
   localparam int DIV_CNT_W   = 3;
   localparam int DIV_PART_W  = 25;   // remainder and next digit, below 100 * 2^18
   localparam int DIV_PROD_W  = 50;   // partial times reciprocal stays below 2^50
   localparam int DIV_SHIFT   = 32;
   localparam logic [25:0] DIV_RECIP = 26'd42949673;   // ceil(2^32 / 100)

   localparam logic [RATIO_W-1:0] PCT_FULL = 7'd100;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_BLEND = 2'd2;
   localparam logic [1:0] CMD_SET   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_MONO  = 2'd2;

   typedef struct packed {
      logic [1:0]                command;
      logic [IDX_W-1:0]          counter_index;
      logic signed [VALUE_W-1:0] operand;
      logic [RATIO_W-1:0]        blend_ratio;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] counter_value;
      logic [1:0]                status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/scb_ram.sv =====
// Counter storage: one write port, one read port with registered read data.
// Depends on scb_pkg for the counter width.
module scb_ram #(
   parameter int DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [scb_pkg::VALUE_W-1:0]       wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [scb_pkg::VALUE_W-1:0]       rd_data
);

   logic [scb_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [scb_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/scb_div100.sv =====
// Divides an unsigned magnitude by the constant 100, 18 dividend bits per step.
// Each quotient digit comes from a reciprocal multiply; four steps. Depends on scb_pkg.
module scb_div100 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [scb_pkg::MAG_W-1:0]     mag,
   output logic                          done,
   output logic [scb_pkg::VALUE_W-1:0]   quot
);

   logic                              busy_ff,  busy_in;
   logic                              done_ff,  done_in;
   logic [scb_pkg::DIV_CNT_W-1:0]     cnt_ff,   cnt_in;
   logic [scb_pkg::DIV_DVD_W-1:0]     shift_ff, shift_in;
   logic [scb_pkg::VALUE_W-1:0]       quot_ff,  quot_in;
   logic [scb_pkg::RATIO_W-1:0]       rem_ff,   rem_in;
   logic [scb_pkg::DIV_PART_W-1:0]    part;
   logic [scb_pkg::DIV_PROD_W-1:0]    prod;
   logic [scb_pkg::DIV_DIGIT_W-1:0]   qdig;
   logic [scb_pkg::DIV_PART_W-1:0]    back;

   // shift_ff hands out dividend digits from the top; quot_ff takes quotient digits in
   always_comb begin
      part = {rem_ff, shift_ff[scb_pkg::DIV_DVD_W-1 -: scb_pkg::DIV_DIGIT_W]};
      prod = scb_pkg::DIV_PROD_W'(part) * scb_pkg::DIV_PROD_W'(scb_pkg::DIV_RECIP);
      qdig = scb_pkg::DIV_DIGIT_W'(prod >> scb_pkg::DIV_SHIFT);
      back = scb_pkg::DIV_PART_W'(qdig) * scb_pkg::DIV_PART_W'(scb_pkg::PCT_FULL);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = scb_pkg::DIV_CNT_W'(scb_pkg::DIV_STEPS);
         shift_in = scb_pkg::DIV_DVD_W'(mag);
         quot_in  = '0;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = shift_ff << scb_pkg::DIV_DIGIT_W;
         quot_in  = {quot_ff[scb_pkg::VALUE_W-scb_pkg::DIV_DIGIT_W-1:0], qdig};
         rem_in   = scb_pkg::RATIO_W'(part - back);
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == scb_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== hdl/stats_counter_bank_core.sv =====
// Statistics counter bank: BANK_SIZE signed 64-bit counters in one synchronous RAM.
// Accept to response beat: an out-of-range beat goes straight to the response step; read, add
// and set read the RAM and modify the value first; a blend on a non-monotonic counter adds a
// multiply step and the four-step divide by 100. Requests are taken one at a time; the next
// beat is not taken until the response is registered. Reset (synchronous, active high) starts
// a clearing pass that zeroes every counter in the RAM; requests stall until it finishes.
module stats_counter_bank_core #(
   parameter int BANK_SIZE     = 256,
   parameter int NUM_MONOTONIC = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scb_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(BANK_SIZE);

   // Controller state
   scb_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   // Request held through the read-modify-write
   logic [1:0]                          cmd_ff,   cmd_in;
   logic signed [scb_pkg::VALUE_W-1:0]  opnd_ff,  opnd_in;
   logic [scb_pkg::RATIO_W-1:0]         ratio_ff, ratio_in;
   logic [AW-1:0]                       addr_ff,  addr_in;
   logic                                mono_ff,  mono_in;

   // Result being built
   logic signed [scb_pkg::VALUE_W-1:0]  val_ff,   val_in;
   logic [1:0]                          stat_ff,  stat_in;
   logic                                we_ff,    we_in;
   logic signed [scb_pkg::NUM_W-1:0]    pa_ff,    pa_in;
   logic signed [scb_pkg::NUM_W-1:0]    pb_ff,    pb_in;
   logic                                neg_ff,   neg_in;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   scb_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   // Handshake and datapath wires
   logic                                accept;
   logic                                out_free;
   logic                                rsp_load;
   logic                                in_range;
   logic                                req_mono;
   logic [AW+scb_pkg::IDX_W-1:0]        addr_ext;
   logic [AW-1:0]                       req_addr;
   logic [scb_pkg::RATIO_W-1:0]         req_ratio;
   logic signed [scb_pkg::VALUE_W-1:0]  cur;
   logic signed [scb_pkg::NUM_W-1:0]    num_sum;
   logic [scb_pkg::MAG_W-1:0]           num_mag;

   logic                                ram_wr_en;
   logic [AW-1:0]                       ram_wr_addr;
   logic [scb_pkg::VALUE_W-1:0]         ram_wr_data;
   logic                                ram_rd_en;
   logic [scb_pkg::VALUE_W-1:0]         ram_rd_data;

   logic                                div_start;
   logic                                div_done;
   logic [scb_pkg::VALUE_W-1:0]         div_quot;

   // Decode the incoming beat
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_range  = 32'(req_data.counter_index) < 32'(BANK_SIZE);
   assign req_mono  = 32'(req_data.counter_index) < 32'(NUM_MONOTONIC);
   assign addr_ext  = {{AW{1'b0}}, req_data.counter_index};
   assign req_addr  = addr_ext[AW-1:0];
   assign req_ratio = (req_data.blend_ratio > scb_pkg::PCT_FULL) ? scb_pkg::PCT_FULL
                                                                 : req_data.blend_ratio;
   assign cur       = $signed(ram_rd_data);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scb_pkg::ST_CLEAR: begin
            if (clr_addr_ff == AW'(BANK_SIZE - 1)) begin
               state_in = scb_pkg::ST_IDLE;
            end
         end
         scb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = in_range ? scb_pkg::ST_EXEC : scb_pkg::ST_DONE;
            end
         end
         scb_pkg::ST_EXEC: begin
            state_in = (cmd_ff == scb_pkg::CMD_BLEND && !mono_ff) ? scb_pkg::ST_MUL
                                                                  : scb_pkg::ST_DONE;
         end
         scb_pkg::ST_MUL: state_in = scb_pkg::ST_DIV;
         scb_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = scb_pkg::ST_DONE;
            end
         end
         scb_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = scb_pkg::ST_IDLE;
            end
         end
         default: state_in = scb_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs: RAM ports, divider start, response load
   always_comb begin
      req_stall   = 1'b1;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = val_ff;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         scb_pkg::ST_CLEAR: begin
            // sweep zeros through the whole bank
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         scb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ram_rd_en = req_valid && in_range;
         end
         scb_pkg::ST_MUL: div_start = 1'b1;
         scb_pkg::ST_DONE: begin
            // write back and hand the beat over together
            rsp_load  = out_free;
            ram_wr_en = out_free && we_ff;
         end
         default: ;
      endcase
   end

   // Datapath: capture request, modify the read value, assemble the blend
   always_comb begin
      cmd_in   = cmd_ff;
      opnd_in  = opnd_ff;
      ratio_in = ratio_ff;
      addr_in  = addr_ff;
      mono_in  = mono_ff;
      val_in   = val_ff;
      stat_in  = stat_ff;
      we_in    = we_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      neg_in   = neg_ff;
      num_sum  = pa_ff + pb_ff;
      num_mag  = num_sum[scb_pkg::NUM_W-1] ? scb_pkg::MAG_W'(-num_sum)
                                           : scb_pkg::MAG_W'(num_sum);
      if (accept) begin
         cmd_in   = req_data.command;
         opnd_in  = req_data.operand;
         ratio_in = req_ratio;
         addr_in  = req_addr;
         mono_in  = req_mono;
         we_in    = in_range;
         val_in   = '0;
         stat_in  = in_range ? scb_pkg::STAT_OK : scb_pkg::STAT_RANGE;
      end
      if (state_ff == scb_pkg::ST_EXEC) begin
         val_in  = cur;
         stat_in = scb_pkg::STAT_OK;
         case (cmd_ff)
            scb_pkg::CMD_ADD: begin
               if (mono_ff && opnd_ff[scb_pkg::VALUE_W-1]) begin
                  stat_in = scb_pkg::STAT_MONO;
               end else begin
                  val_in = cur + opnd_ff;
               end
            end
            scb_pkg::CMD_BLEND: begin
               if (mono_ff) begin
                  stat_in = scb_pkg::STAT_MONO;
               end
               // weight both sides; the sum is divided by 100 later
               pa_in = scb_pkg::NUM_W'(cur) *
                       scb_pkg::NUM_W'($signed({1'b0, scb_pkg::PCT_FULL - ratio_ff}));
               pb_in = scb_pkg::NUM_W'(opnd_ff) *
                       scb_pkg::NUM_W'($signed({1'b0, ratio_ff}));
            end
            scb_pkg::CMD_SET: begin
               if (mono_ff && (opnd_ff < cur)) begin
                  stat_in = scb_pkg::STAT_MONO;
               end else begin
                  val_in = opnd_ff;
               end
            end
            default: ;
         endcase
      end
      if (state_ff == scb_pkg::ST_MUL) begin
         neg_in = num_sum[scb_pkg::NUM_W-1];
      end
      if (state_ff == scb_pkg::ST_DIV && div_done) begin
         // magnitude quotient truncates toward zero; restore the sign
         val_in = neg_ff ? -$signed(div_quot) : $signed(div_quot);
      end
   end

   // Response register: hold while stalled, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.counter_value = val_ff;
         rsp_data_in.status        = stat_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scb_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      opnd_ff     <= opnd_in;
      ratio_ff    <= ratio_in;
      addr_ff     <= addr_in;
      mono_ff     <= mono_in;
      val_ff      <= val_in;
      stat_ff     <= stat_in;
      we_ff       <= we_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   scb_ram #(
      .DEPTH (BANK_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   scb_div100 u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (num_mag),
      .done  (div_done),
      .quot  (div_quot)
   );

`ifndef NO_ASSERTIONS
   // a response beat only appears out of the write-back step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == scb_pkg::ST_DONE)
      else $error("response raised outside write-back");

   // out-of-range beats carry a zero value
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == scb_pkg::STAT_RANGE) |-> rsp_data.counter_value == '0)
      else $error("out-of-range response carries a value");

   // never write back for a refused index
   a_no_range_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scb_pkg::ST_DONE && we_ff) |-> stat_ff != scb_pkg::STAT_RANGE)
      else $error("write-back armed for an out-of-range index");

   // the divider finishes only while the controller waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == scb_pkg::ST_DIV)
      else $error("divider done outside blend wait");
`endif

endmodule
